// ----- rtl/core/bblc_pkg.sv -----
// Package for the Bayer black level correction block.
// Holds register indexes, widths and the controller/datapath command types.
// Depends on nothing.
`default_nettype none
package bblc_pkg;
  localparam int unsigned PixW = 16;
  localparam int unsigned LwW = 14;
  localparam int unsigned MaxLineWidth = 8192;
  localparam int unsigned ColW = $clog2(MaxLineWidth);
  localparam int unsigned ProdW = 2 * PixW;
  localparam int unsigned QuoW = ProdW;
  localparam int unsigned DivCntW = $clog2(QuoW + 1);

  localparam logic [2:0] RegBlackRed = 3'd0;
  localparam logic [2:0] RegBlackGrRow = 3'd1;
  localparam logic [2:0] RegBlackGbRow = 3'd2;
  localparam logic [2:0] RegBlackBlue = 3'd3;
  localparam logic [2:0] RegWhite = 3'd4;
  localparam logic [2:0] RegMosaic = 3'd5;
  localparam logic [2:0] RegLineWidth = 3'd6;

  typedef struct packed {
    logic load;     // capture pixel and start a transaction
    logic mul;      // form the product
    logic div_step; // one restoring division step
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/bayer_black_level_correction.sv -----
// Top level of the Bayer black level correction block.
// Joins bblc_ctrl and bblc_dp; depends on bblc_pkg.
`default_nettype none
// Each pixel becomes floor((raw - black) * white / (white - black)), saturated
// to 16 bits, with black chosen per Bayer channel from row/column parity and
// the mosaic order; frame_start (tuser) resets position. Each pixel is loaded,
// multiplied, passed through 32 steps of the bit-serial restoring divider and
// then presented as a result; the next pixel is accepted after the result
// transaction completes. Configuration writes take effect at once and must be made while idle.
module bayer_black_level_correction (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // [15:0] raw_value
  input  wire logic        s_axis_tuser_i,  // [0] frame_start
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // [15:0] corrected_value
  output logic [1:0]       m_axis_tuser_o   // [0] clipped, [1] bad_config
);
  bblc_pkg::dp_cmd_t cmd;
  bblc_pkg::dp_sts_t sts;
  logic clip, bad;

  bblc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .cmd_o(cmd), .sts_i(sts)
  );

  bblc_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .raw_i(s_axis_tdata_i), .fs_i(s_axis_tuser_i),
    .cmd_i(cmd), .sts_o(sts),
    .value_o(m_axis_tdata_o), .clip_o(clip), .bad_o(bad)
  );

  assign m_axis_tuser_o = {bad, clip};
endmodule
`default_nettype wire

// ----- rtl/core/bblc_ctrl.sv -----
// Controller for the Bayer black level correction block.
// Sequences load, multiply, divide and output; depends on bblc_pkg.
`default_nettype none
module bblc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output bblc_pkg::dp_cmd_t      cmd_o,
  input  wire bblc_pkg::dp_sts_t sts_i
);
  typedef enum logic [1:0] {StIdle, StMul, StDiv, StOut} state_e;
  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_ready_o && in_valid_i;
    cmd_o.mul      = (state_q == StMul);
    cmd_o.div_step = (state_q == StDiv) && !sts_i.div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: if (in_valid_i) state_q <= StMul;
        StMul: state_q <= StDiv;
        StDiv: begin
          if (sts_i.div_done) begin
            state_q     <= StOut;
            out_valid_q <= 1'b1;
          end
        end
        StOut: begin
          if (out_ready_i) begin
            state_q     <= StIdle;
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == StOut)) else $error("output valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o) else $error("input taken while result pending");
  a_load_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == StMul)) else $error("load did not advance to multiply");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/bblc_dp.sv -----
// Datapath for the Bayer black level correction block.
// Holds config, position counters, multiplier and serial divider; depends on bblc_pkg.
`default_nettype none
module bblc_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [2:0]                cfg_idx_i,
  input  wire logic [bblc_pkg::PixW-1:0] cfg_data_i,
  input  wire logic [bblc_pkg::PixW-1:0] raw_i,
  input  wire logic                      fs_i,
  input  wire bblc_pkg::dp_cmd_t         cmd_i,
  output bblc_pkg::dp_sts_t              sts_o,
  output logic [bblc_pkg::PixW-1:0]      value_o,
  output logic                           clip_o,
  output logic                           bad_o
);
  localparam int unsigned PW = bblc_pkg::PixW;
  localparam int unsigned QW = bblc_pkg::QuoW;
  localparam int unsigned CW = bblc_pkg::ColW;

  logic [PW-1:0] blk_q [4];
  logic [PW-1:0] white_q;
  logic [1:0]    mosaic_q;
  logic [bblc_pkg::LwW-1:0] lw_q;
  logic [CW-1:0] col_q;
  logic          row_q;

  logic [PW-1:0] diff_q, den_q;
  logic          bad_q, below_q;
  logic [QW-1:0] num_q, quo_q;
  logic [PW:0]   rem_q;
  logic [bblc_pkg::DivCntW-1:0] cnt_q;

  // Effective width: zero means one, clamp at the maximum.
  logic [bblc_pkg::LwW-1:0] eff_w;
  always_comb begin
    eff_w = lw_q;
    if (lw_q == '0) eff_w = bblc_pkg::LwW'(1);
    if (lw_q > bblc_pkg::LwW'(bblc_pkg::MaxLineWidth))
      eff_w = bblc_pkg::LwW'(bblc_pkg::MaxLineWidth);
  end

  logic [CW-1:0] col_c;
  logic          row_c;
  logic [1:0]    chan;
  logic [PW-1:0] blk;
  logic [CW:0]   col_nx;
  assign col_c  = fs_i ? '0 : col_q;
  assign row_c  = fs_i ? 1'b0 : row_q;
  assign chan   = {row_c ^ mosaic_q[1], col_c[0] ^ mosaic_q[0]};
  assign blk    = blk_q[chan];
  assign col_nx = {1'b0, col_c} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) blk_q[i] <= '0;
      white_q  <= '1;
      mosaic_q <= '0;
      lw_q     <= bblc_pkg::LwW'(1);
      col_q    <= '0;
      row_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bblc_pkg::RegBlackRed:   blk_q[0] <= cfg_data_i;
          bblc_pkg::RegBlackGrRow: blk_q[1] <= cfg_data_i;
          bblc_pkg::RegBlackGbRow: blk_q[2] <= cfg_data_i;
          bblc_pkg::RegBlackBlue:  blk_q[3] <= cfg_data_i;
          bblc_pkg::RegWhite:      white_q  <= cfg_data_i;
          bblc_pkg::RegMosaic:     mosaic_q <= cfg_data_i[1:0];
          bblc_pkg::RegLineWidth:  lw_q     <= cfg_data_i[bblc_pkg::LwW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        if ({1'b0, col_nx} >= {1'b0, eff_w}) begin
          col_q <= '0;
          row_q <= ~row_c;
        end else begin
          col_q <= col_nx[CW-1:0];
          row_q <= row_c;
        end
      end
    end
  end

  // Payload: load, multiply, then restoring division one bit a cycle.
  logic [PW:0] trial;
  assign trial = {rem_q[PW-1:0], num_q[QW-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bad_q   <= (white_q <= blk);
      below_q <= (raw_i < blk);
      diff_q  <= raw_i - blk;
      den_q   <= white_q - blk;
    end
    if (cmd_i.mul) begin
      num_q <= QW'(diff_q) * QW'(white_q);
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      num_q <= {num_q[QW-2:0], 1'b0};
      if (!trial[PW]) begin
        rem_q <= trial;
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[PW-1:0], num_q[QW-1]};
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign sts_o.div_done = (cnt_q == bblc_pkg::DivCntW'(QW));

  logic ovf;
  assign ovf = |quo_q[QW-1:PW];
  always_comb begin
    value_o = '0;
    clip_o  = 1'b0;
    bad_o   = 1'b0;
    if (bad_q) bad_o = 1'b1;
    else if (below_q) clip_o = 1'b1;
    else if (ovf) begin
      value_o = '1;
      clip_o  = 1'b1;
    end else value_o = quo_q[PW-1:0];
  end
endmodule
`default_nettype wire

// ----- bench/bayer_black_level_correction_test.sv -----
// Self-checking testbench for the Bayer black level correction block.
// Drives pixel streams with random gaps and back-pressure, predicts each
// corrected pixel in place and compares it; depends on bblc_pkg.
`timescale 1ns / 100ps
module bayer_black_level_correction_test;

  typedef struct packed {
    logic [15:0] value;
    logic        clip;
    logic        bad;
  } pix_out_t;

  typedef struct {
    logic [15:0] raw;
    logic        fs;
    logic        known;  // expected result is typed in below
    pix_out_t    res;
  } stim_row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [15:0] cfg_data;
  logic s_valid, s_ready, m_valid, m_ready;
  logic [15:0] s_data, m_data;
  logic s_user;
  logic [1:0] m_user;

  // predictor copy of registers and position
  logic [15:0] blk [4];
  logic [15:0] white;
  logic [1:0]  mosaic;
  logic [13:0] lwidth;
  int unsigned col_pos;
  logic        row_par;

  pix_out_t pending_pixels[$];
  int errors;
  int mismatches;
  int held;         // long receiver hold-off, cycles left
  bit no_idle;      // stretch without idling
  bit done;

  bayer_black_level_correction DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Predict one pixel and advance the raster position.
  function automatic pix_out_t correct_pixel(logic [15:0] raw, logic fs);
    pix_out_t o;
    logic [1:0] ch;
    logic [15:0] b;
    logic [31:0] q;
    int unsigned w;
    o = '0;
    if (fs) begin
      col_pos = 0;
      row_par = 0;
    end
    ch = {row_par ^ mosaic[1], col_pos[0] ^ mosaic[0]};
    b = blk[ch];
    if (white <= b) o.bad = 1;
    else if (raw < b) o.clip = 1;
    else begin
      q = (32'(raw - b) * 32'(white)) / 32'(white - b);
      if (q > 32'hFFFF) begin
        o.value = 16'hFFFF;
        o.clip = 1;
      end else o.value = q[15:0];
    end
    w = (lwidth == 0) ? 1 : (lwidth > bblc_pkg::MaxLineWidth ?
                             bblc_pkg::MaxLineWidth : lwidth);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_par ^= 1;
    end
    return o;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      bblc_pkg::RegBlackRed:   blk[0] = val;
      bblc_pkg::RegBlackGrRow: blk[1] = val;
      bblc_pkg::RegBlackGbRow: blk[2] = val;
      bblc_pkg::RegBlackBlue:  blk[3] = val;
      bblc_pkg::RegWhite:      white = val;
      bblc_pkg::RegMosaic:     mosaic = val[1:0];
      bblc_pkg::RegLineWidth:  lwidth = val[13:0];
      default: ;
    endcase
  endtask

  // Send one pixel transaction; idle first at random.
  task automatic send_pixel(logic [15:0] raw, logic fs, bit known, pix_out_t res);
    pix_out_t p;
    if (!no_idle && $urandom_range(99) < 35) begin
      s_valid <= 0;
      do @(posedge clk); while (!no_idle && $urandom_range(99) < 35);
    end
    p = correct_pixel(raw, fs);
    if (known && p != res) begin
      errors++;
      $display("table row mismatch: raw %h predicted %p typed %p", raw, p, res);
    end
    pending_pixels.push_back(p);
    s_valid <= 1;
    s_data <= raw;
    s_user <= fs;
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic drain();
    s_valid <= 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off when requested.
  always @(posedge clk) begin
    if (held > 0) begin
      held <= held - 1;
      m_ready <= 0;
    end else m_ready <= no_idle || ($urandom_range(99) >= 35);
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    pix_out_t want;
    if (rst_n && m_valid && m_ready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h %b", m_data, m_user);
      end else begin
        want = pending_pixels.pop_front();
        if (m_data !== want.value || m_user[0] !== want.clip || m_user[1] !== want.bad)
        begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: want %h clip %b bad %b, got %h clip %b bad %b",
                     want.value, want.clip, want.bad, m_data, m_user[0], m_user[1]);
        end
      end
    end
  end

  stim_row_t dir_rows[$];

  task automatic add_row(logic [15:0] raw, logic fs, bit known, pix_out_t res);
    stim_row_t r;
    r.raw = raw; r.fs = fs; r.known = known; r.res = res;
    dir_rows.push_back(r);
  endtask

  task automatic rand_config();
    int unsigned k;
    for (int i = 0; i < 4; i++) begin
      k = $urandom_range(9);
      write_reg(3'(i), k == 0 ? 16'hFFFF : (k < 3 ? 16'h0 : 16'($urandom_range(4095))));
    end
    k = $urandom_range(9);
    write_reg(bblc_pkg::RegWhite, k == 0 ? 16'($urandom_range(4095)) :
              (k < 4 ? 16'hFFFF : 16'($urandom_range(65535, 8192))));
    write_reg(bblc_pkg::RegMosaic, 16'($urandom_range(3)));
    k = $urandom_range(19);
    write_reg(bblc_pkg::RegLineWidth, k == 0 ? 16'h3FFF : (k == 1 ? 16'd0 :
              (k == 2 ? 16'd8192 : 16'($urandom_range(9, 1)))));
    if ($urandom_range(3) == 0) write_reg(3'd7, 16'($urandom));  // unused index
  endtask

  initial begin
    int unsigned phase_len;
    held = 0; no_idle = 0; done = 0; errors = 0; mismatches = 0;
    blk[0] = 0; blk[1] = 0; blk[2] = 0; blk[3] = 0;
    white = 16'hFFFF; mosaic = 0; lwidth = 1; col_pos = 0; row_par = 0;
    cfg_we = 0; cfg_idx = 0; cfg_data = 0;
    s_valid = 0; s_data = 0; s_user = 0; m_ready = 0;
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // After reset: gain is unity, black zero.
    add_row(16'h0000, 1, 1, '{16'h0000, 0, 0});
    add_row(16'hFFFF, 0, 1, '{16'hFFFF, 0, 0});
    add_row(16'h1234, 0, 1, '{16'h1234, 0, 0});
    foreach (dir_rows[i]) send_pixel(dir_rows[i].raw, dir_rows[i].fs,
                                     dir_rows[i].known, dir_rows[i].res);
    drain();

    // Distinct black per channel, 4-pixel rows, every mosaic order.
    write_reg(bblc_pkg::RegBlackRed, 16'd100);
    write_reg(bblc_pkg::RegBlackGrRow, 16'd200);
    write_reg(bblc_pkg::RegBlackGbRow, 16'd300);
    write_reg(bblc_pkg::RegBlackBlue, 16'hFFFF);
    write_reg(bblc_pkg::RegWhite, 16'hF000);
    write_reg(bblc_pkg::RegLineWidth, 16'd4);
    for (int m = 0; m < 4; m++) begin
      write_reg(bblc_pkg::RegMosaic, 16'(m));
      dir_rows.delete();
      add_row(16'd50, 1, 0, '0);       // below black
      add_row(16'hFFFF, 0, 0, '0);     // overflow, or bad on the blue channel
      add_row(16'd300, 0, 0, '0);
      add_row(16'd7, 0, 0, '0);
      add_row(16'h8000, 0, 0, '0);
      foreach (dir_rows[i]) send_pixel(dir_rows[i].raw, dir_rows[i].fs, 0, '0);
      drain();
    end
    // White at or below black: bad configuration on every channel.
    write_reg(bblc_pkg::RegBlackRed, 16'h0000);
    write_reg(bblc_pkg::RegWhite, 16'h0000);
    dir_rows.delete();
    add_row(16'hFFFF, 1, 1, '{16'h0000, 0, 1});
    foreach (dir_rows[i]) send_pixel(dir_rows[i].raw, dir_rows[i].fs,
                                     dir_rows[i].known, dir_rows[i].res);
    drain();

    // Random phases with a frame start at each phase start and at random pixels.
    for (int ph = 0; ph < 26; ph++) begin
      rand_config();
      no_idle = (ph == 5);
      phase_len = 50;
      for (int n = 0; n < phase_len; n++) begin
        if (ph == 8 && n == 10) held = 400;  // block fills and stalls input
        send_pixel(16'($urandom), (n == 0) || ($urandom_range(29) == 0), 0, '0);
        if (ph == 12 && n == 25) begin
          s_valid <= 0;
          while (pending_pixels.size() != 0) @(posedge clk);
        end
      end
      no_idle = 0;
      drain();
    end

    drain();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ----- bayer_black_level_correction.f -----
rtl/core/bblc_pkg.sv
rtl/core/bblc_ctrl.sv
rtl/core/bblc_dp.sv
rtl/core/bayer_black_level_correction.sv
bench/bayer_black_level_correction_test.sv
